@@ design/lide_pkg.sv @@
// Shared constants, opcodes and control/status types for the list engine.
// No dependencies; imported by lide_ctrl, lide_dpath and the top level.
package lide_pkg;

	// store sizing
	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 64;
	localparam int OP_W     = 2;
	localparam int POS_W    = 4;
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

	// operation codes
	localparam logic [OP_W-1:0] OP_FRONT  = 2'd0;
	localparam logic [OP_W-1:0] OP_BACK   = 2'd1;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic capture;   // latch the incoming beat
		logic update;    // apply the latched operation to the store
		logic load;      // move one listing entry into the output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;  // output register can take a new beat this cycle
		logic last;      // the entry at the listing index is the final one
	} status_t;

endpackage

@@ design/lide_ctrl.sv @@
// Sequencer for the list engine: capture, update, then one listing beat per cycle unless the output stalls.
// Depends on lide_pkg for cmd_t and status_t.
module lide_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  lide_pkg::status_t st,
	output lide_pkg::cmd_t    cmd
);
	import lide_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_UPDATE,
		S_LIST
	} state_t;

	state_t state_q;

	// command decode
	always_comb begin
		cmd         = '0;
		cmd.capture = in_valid && (state_q == S_IDLE);
		cmd.update  = (state_q == S_UPDATE);
		cmd.load    = (state_q == S_LIST) && st.out_free;
	end

	assign in_stall = (state_q != S_IDLE);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					state_q <= S_LIST;
				end
				S_LIST: begin
					if (st.out_free && st.last) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ design/lide_dpath.sv @@
// Datapath of the list engine: entry registers, count, listing index, output register.
// Depends on lide_pkg for sizing, opcodes, cmd_t and status_t.
module lide_dpath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  lide_pkg::cmd_t                   cmd,
	output lide_pkg::status_t                st,
	input  logic [lide_pkg::OP_W-1:0]        op,
	input  logic signed [lide_pkg::VAL_W-1:0] value,
	input  logic [lide_pkg::POS_W-1:0]       position,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [lide_pkg::VAL_W-1:0] entry_value,
	output logic                             is_empty,
	output logic                             is_last,
	output logic                             dropped
);
	import lide_pkg::*;

	logic [OP_W-1:0]         op_q;
	logic signed [VAL_W-1:0] value_q;
	logic [POS_W-1:0]        pos_q;
	logic [VAL_W-1:0]        entries_q [CAPACITY];
	logic [CNT_W-1:0]        count_q;
	logic [IDX_W-1:0]        idx_q;
	logic                    drop_q;

	logic is_ins, full, del_hit, empty_now;

	assign is_ins    = (op_q == OP_FRONT) || (op_q == OP_BACK);
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign del_hit   = (op_q == OP_DELETE) && (CMP_W'(pos_q) < CMP_W'(count_q));
	assign empty_now = (count_q == '0);

	// status back to the controller
	assign st.out_free = !out_valid || !out_stall;
	assign st.last     = empty_now || ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);

	// latch the input beat
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= op;
			value_q <= value;
			pos_q   <= position;
		end
	end

	// entry store: shift for front insert and delete, indexed write for append
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			if (is_ins && !full) begin
				if (op_q == OP_FRONT) begin
					entries_q[0] <= value_q;
					for (int i = 1; i < CAPACITY; i++) begin
						entries_q[i] <= entries_q[i-1];
					end
				end else begin
					entries_q[IDX_W'(count_q)] <= value_q;
				end
			end else if (del_hit) begin
				for (int i = 0; i < CAPACITY - 1; i++) begin
					if (CMP_W'(i) >= CMP_W'(pos_q)) entries_q[i] <= entries_q[i+1];
				end
			end
		end
	end

	// count, drop flag and listing index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
			drop_q  <= 1'b0;
		end else if (cmd.update) begin
			idx_q  <= '0;
			drop_q <= is_ins && full;
			if (is_ins && !full) count_q <= count_q + CNT_W'(1);
			else if (del_hit)    count_q <= count_q - CNT_W'(1);
		end else if (cmd.load) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			entry_value <= empty_now ? '0 : entries_q[idx_q];
			is_empty    <= empty_now;
			is_last     <= st.last;
			dropped     <= drop_q;
		end
	end

endmodule

@@ design/list_insert_delete_engine_top.sv @@
// Ordered store of up to CAPACITY signed values: insert front, append back, delete at index.
// Sequence: the input beat is latched, the store is updated, then the listing is emitted.
// in_stall holds off a new item until its last listing beat has been loaded, the single
// listing read port emitting one entry per cycle unless the output stalls.
// Reset: arst_n asynchronously empties the store and clears the sequencer and output valid.
module list_insert_delete_engine_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [lide_pkg::OP_W-1:0]         op,
	input  logic signed [lide_pkg::VAL_W-1:0] value,
	input  logic [lide_pkg::POS_W-1:0]        position,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [lide_pkg::VAL_W-1:0] entry_value,
	output logic                              is_empty,
	output logic                              is_last,
	output logic                              dropped
);
	import lide_pkg::*;

	cmd_t    cmd;
	status_t st;

	// sequencer
	lide_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	// store and output register
	lide_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.op          (op),
		.value       (value),
		.position    (position),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.entry_value (entry_value),
		.is_empty    (is_empty),
		.is_last     (is_last),
		.dropped     (dropped)
	);

endmodule

@@ tb/sv/tb.sv @@
// Self-checking bench for list_insert_delete_engine_top: mirrors the ordered store and
// checks every listing beat. Needs lide_pkg and the engine RTL only.
`timescale 1ns / 1ps

module tb;
	import lide_pkg::*;

	// op code the engine must treat as a no-op that still lists the store
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam logic signed [VAL_W-1:0] VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 64'sh8000_0000_0000_0000;
	localparam int PHASE_ITEMS = 96;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_LIMIT = 20000;

	// one beat of a listing
	typedef struct {
		logic signed [VAL_W-1:0] val;
		bit empty;
		bit last;
		bit drop;
	} listing_beat_t;

	// mirror of the store plus the queue of listing beats still owed by the engine
	class list_shadow;
		logic signed [VAL_W-1:0] store [CAPACITY];
		int unsigned fill;
		listing_beat_t listing_q [$];
		int mismatches;
		int n_front, n_back, n_delete, n_unused, n_refused, n_miss_delete, n_beats, peak;

		function void report_miss(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("[%0t] ERROR: %s", $time, msg);
		endfunction

		function int unsigned count();
			return fill;
		endfunction

		function int outstanding();
			return listing_q.size();
		endfunction

		// apply one accepted operation and queue the listing it produces
		function void apply_op(logic [OP_W-1:0] op_code, logic signed [VAL_W-1:0] val,
				logic [POS_W-1:0] pos);
			bit drop;
			listing_beat_t b;
			drop = 0;
			if (op_code == OP_FRONT || op_code == OP_BACK) begin
				if (op_code == OP_FRONT)
					n_front++;
				else
					n_back++;
				if (fill == CAPACITY) begin
					drop = 1;
					n_refused++;
				end else if (op_code == OP_FRONT) begin
					for (int i = fill; i > 0; i--)
						store[i] = store[i-1];
					store[0] = val;
					fill++;
				end else begin
					store[fill] = val;
					fill++;
				end
			end else if (op_code == OP_DELETE) begin
				n_delete++;
				if (pos < fill) begin
					for (int i = pos; i + 1 < fill; i++)
						store[i] = store[i+1];
					fill--;
				end else begin
					n_miss_delete++;
				end
			end else begin
				n_unused++;
			end
			if (fill > peak)
				peak = fill;

			// empty store lists as a single marked beat
			if (fill == 0) begin
				b.val = '0;
				b.empty = 1;
				b.last = 1;
				b.drop = drop;
				listing_q.push_back(b);
			end else begin
				for (int i = 0; i < fill; i++) begin
					b.val = store[i];
					b.empty = 0;
					b.last = (i + 1 == fill);
					b.drop = drop;
					listing_q.push_back(b);
				end
			end
		endfunction

		// compare one accepted result beat with the oldest owed beat
		function void check_beat(logic signed [VAL_W-1:0] val, logic empty, logic last,
				logic drop);
			listing_beat_t want;
			if (listing_q.size() == 0) begin
				report_miss($sformatf("unexpected beat value=%0d empty=%b last=%b drop=%b",
					val, empty, last, drop));
				return;
			end
			want = listing_q.pop_front();
			n_beats++;
			if (val !== want.val || empty !== want.empty || last !== want.last ||
					drop !== want.drop)
				report_miss($sformatf(
					"beat %0d: want value=%0d empty=%b last=%b drop=%b, got %0d %b %b %b",
					n_beats, want.val, want.empty, want.last, want.drop,
					val, empty, last, drop));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [OP_W-1:0] op;
	logic signed [VAL_W-1:0] value;
	logic [POS_W-1:0] position;
	logic out_valid;
	logic out_stall;
	logic signed [VAL_W-1:0] entry_value;
	logic is_empty;
	logic is_last;
	logic dropped;

	list_shadow shadow;
	int idle_pct;
	int stall_pct;
	int hold_request;

	list_insert_delete_engine_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.value       (value),
		.position    (position),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.entry_value (entry_value),
		.is_empty    (is_empty),
		.is_last     (is_last),
		.dropped     (dropped)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// hard stop if the engine hangs
	initial begin
		#5000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// receiver: random stalls, plus a long hold-off counted here when requested
	initial begin
		int hold_left;
		hold_left = 0;
		out_stall = 0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			shadow.check_beat(entry_value, is_empty, is_last, dropped);
	end

	// value mix: extremes and small numbers show up often, the rest is full-width random
	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return VAL_MAX;
			1: return VAL_MIN;
			2: return '0;
			3: return -64'sd1;
			4: return $signed({{48{1'b0}}, 16'($urandom)});
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// offer one beat, idling first at random, and hold it until accepted
	task automatic send_item(input logic [OP_W-1:0] op_code,
			input logic signed [VAL_W-1:0] val, input logic [POS_W-1:0] pos);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op <= op_code;
		value <= val;
		position <= pos;
		do
			@(posedge clk);
		while (in_stall);
		shadow.apply_op(op_code, val, pos);
	endtask

	// random operation; deletes mostly hit a live index so the store moves around
	task automatic send_random(input int insert_pct);
		int roll;
		int unsigned fill;
		logic [OP_W-1:0] op_code;
		logic [POS_W-1:0] pos;
		roll = $urandom_range(0, 99);
		fill = shadow.count();
		if (roll < 3)
			op_code = OP_UNUSED;
		else if (roll < 3 + insert_pct * 97 / 100)
			op_code = $urandom_range(0, 1) ? OP_BACK : OP_FRONT;
		else
			op_code = OP_DELETE;
		if (fill > 0 && $urandom_range(0, 4) != 0)
			pos = POS_W'($urandom_range(0, fill - 1));
		else
			pos = POS_W'($urandom_range(0, 15));
		send_item(op_code, pick_value(), pos);
	endtask

	initial begin
		int phase_idle [4];
		int phase_stall [4];
		int insert_mix [4];
		shadow = new();
		phase_idle = '{0, 84, 0, 16};
		phase_stall = '{0, 0, 84, 16};
		insert_mix = '{85, 20, 55, 90};
		idle_pct = 0;
		stall_pct = 0;
		hold_request = 0;
		arst_n = 0;
		in_valid = 0;
		op = OP_FRONT;
		value = '0;
		position = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: empty store, fill to capacity, refused inserts, edge deletes
		send_item(OP_DELETE, '0, 4'd0);
		send_item(OP_UNUSED, pick_value(), 4'd15);
		send_item(OP_FRONT, VAL_MAX, 4'd15);
		send_item(OP_BACK, VAL_MIN, 4'd0);
		send_item(OP_FRONT, '0, 4'd0);
		send_item(OP_BACK, -64'sd1, 4'd0);
		for (int i = 0; i < CAPACITY - 4; i++)
			send_item((i % 2) ? OP_BACK : OP_FRONT, pick_value(), 4'($urandom));
		send_item(OP_FRONT, pick_value(), 4'd0);
		send_item(OP_BACK, pick_value(), 4'd0);
		send_item(OP_DELETE, pick_value(), 4'd15);
		send_item(OP_DELETE, pick_value(), 4'd0);
		send_item(OP_DELETE, pick_value(), 4'd14);
		send_item(OP_DELETE, pick_value(), 4'd15);
		send_item(OP_UNUSED, pick_value(), 4'd7);

		// random phases with different idling on each side
		for (int p = 0; p < 4; p++) begin
			idle_pct = phase_idle[p];
			stall_pct = phase_stall[p];
			if (p == 0)
				hold_request = HOLD_CYCLES;
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_random(insert_mix[(n / 24) % 4]);
		end

		@(negedge clk);
		in_valid <= 1'b0;
		stall_pct = 0;
		for (int t = 0; t < DRAIN_LIMIT && shadow.outstanding() != 0; t++)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Ran %0d front, %0d back, %0d delete (%0d out of range), %0d unused-op items",
			shadow.n_front, shadow.n_back, shadow.n_delete, shadow.n_miss_delete,
			shadow.n_unused);
		$display("Checked %0d listing beats; %0d refused inserts; peak fill %0d of %0d",
			shadow.n_beats, shadow.n_refused, shadow.peak, CAPACITY);
		if (shadow.outstanding() != 0)
			$display("ERROR: %0d listing beats never arrived", shadow.outstanding());
		if (shadow.mismatches == 0 && shadow.outstanding() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
